FILE: rtl/core/ntn_pkg.sv
`default_nettype none
package ntn_pkg;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 48;
    localparam logic [CfgIdxW-1:0] REG_ENABLE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ROW_X = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ROW_Y = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_ROW_Z = 2'd3;
    localparam int VecW = 34;   // transformed component, signed
    localparam int MagW = 33;   // magnitude of a component
    localparam int ScW = 16;    // scaled magnitude, 2^15 <= max < 2^16
    localparam int SumW = 34;   // sum of three squares
    localparam int RootW = 17;  // floor(sqrt(sum))
    localparam int QW = 15;     // quotient 0..16384
    localparam int NumW = 31;   // a*16384 + L/2

    // slot: sign extended, low bits dropped below the coefficient width
    function automatic logic signed [15:0] coef_slot(input logic [15:0] raw,
                                                     input int cw);
        logic [15:0] mask;
        mask = (cw < 16) ? (16'hFFFF << (16 - cw)) : 16'hFFFF;
        return signed'(raw & mask);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ntn_sqrt.sv
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module ntn_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [ntn_pkg::SumW-1:0]      i_sum,
    output logic      [ntn_pkg::RootW-1:0]     o_root
);
    localparam int N = ntn_pkg::RootW;
    localparam int RemW = ntn_pkg::SumW + 2;

    logic [RemW-1:0]            r_rem  [N+1];
    logic [ntn_pkg::RootW-1:0]  r_root [N+1];
    logic [ntn_pkg::SumW-1:0]   r_val  [N+1];

    always_comb begin
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_val[0]  = i_sum;
    end

    // restoring root: bring in two bits, try (4*root+1)
    for (genvar g = 0; g < N; g++) begin : g_st
        logic [RemW-1:0]           n_rem;
        logic [RemW-1:0]           n_trial;
        logic [ntn_pkg::RootW-1:0] n_root;
        logic [RemW-1:0]           r_rem_q;
        logic [ntn_pkg::RootW-1:0] r_root_q;
        logic [ntn_pkg::SumW-1:0]  r_val_q;
        always_comb begin
            n_rem   = {r_rem[g][RemW-3:0], r_val[g][ntn_pkg::SumW-1 -: 2]};
            n_trial = RemW'({r_root[g][ntn_pkg::RootW-1:0], 2'b01});
            if (n_rem >= n_trial) begin
                n_rem  = n_rem - n_trial;
                n_root = {r_root[g][ntn_pkg::RootW-2:0], 1'b1};
            end else begin
                n_root = {r_root[g][ntn_pkg::RootW-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_q  <= n_rem;
                r_root_q <= n_root;
                r_val_q  <= {r_val[g][ntn_pkg::SumW-3:0], 2'b00};
            end
        end
        always_comb begin
            r_rem[g+1]  = r_rem_q;
            r_root[g+1] = r_root_q;
            r_val[g+1]  = r_val_q;
        end
    end

    assign o_root = r_root[N];
endmodule
`default_nettype wire

FILE: rtl/core/ntn_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module ntn_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ntn_pkg::NumW-1:0]  i_num,
    input  wire logic [ntn_pkg::RootW-1:0] i_den,
    output logic      [ntn_pkg::QW-1:0]    o_quo
);
    localparam int N = ntn_pkg::QW;
    localparam int RW = ntn_pkg::RootW + 1;
    // quotient < 2^15, so the top numerator bits fit below the divisor
    localparam int HiW = ntn_pkg::NumW - N;

    logic [RW-1:0]              s_rem [N+1];
    logic [N-1:0]               s_low [N+1];
    logic [N-1:0]               s_quo [N+1];
    logic [ntn_pkg::RootW-1:0]  s_den [N+1];

    always_comb begin
        s_rem[0] = RW'(i_num[ntn_pkg::NumW-1 -: HiW]);
        s_low[0] = i_num[N-1:0];
        s_quo[0] = '0;
        s_den[0] = i_den;
    end

    for (genvar g = 0; g < N; g++) begin : g_st
        logic [RW-1:0]             n_rem;
        logic [RW-1:0]             r_rem_q;
        logic [N-1:0]              r_low_q;
        logic [N-1:0]              r_quo_q;
        logic [ntn_pkg::RootW-1:0] r_den_q;
        logic                      n_bit;
        always_comb begin
            n_rem = {s_rem[g][RW-2:0], s_low[g][N-1]};
            n_bit = (n_rem >= RW'(s_den[g]));
            if (n_bit) n_rem = n_rem - RW'(s_den[g]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_q <= n_rem;
                r_low_q <= {s_low[g][N-2:0], 1'b0};
                r_quo_q <= {s_quo[g][N-2:0], n_bit};
                r_den_q <= s_den[g];
            end
        end
        always_comb begin
            s_rem[g+1] = r_rem_q;
            s_low[g+1] = r_low_q;
            s_quo[g+1] = r_quo_q;
            s_den[g+1] = r_den_q;
        end
    end

    assign o_quo = s_quo[N];
endmodule
`default_nettype wire

FILE: rtl/core/normal_transform_normalize_core.sv
`default_nettype none
// Pipeline: product, sum, scaling and sum-of-squares stages, then root, divide and output.
// Throughput: one transaction per cycle; the whole pipeline advances on a
// single enable, so an output stall holds every stage (the output register
// takes a new item whenever it is empty or being drained).
// Reset: synchronous active low; clears valid bits and loads the config
// registers with their reset rows, transform off. Data registers are not reset.
module normal_transform_normalize_core #(
    parameter int COEF_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ntn_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  wire logic [ntn_pkg::CfgDataW-1:0]   i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [15:0]             i_normal_in_x,
    input  wire logic signed [15:0]             i_normal_in_y,
    input  wire logic signed [15:0]             i_normal_in_z,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [15:0]                  o_unit_x,
    output logic signed [15:0]                  o_unit_y,
    output logic signed [15:0]                  o_unit_z,
    output logic                                o_zero_length
);
    localparam int SqL = ntn_pkg::RootW;
    localparam int DvL = ntn_pkg::QW;
    localparam int Depth = 4 + SqL + DvL;

    // config registers
    logic        r_en;
    logic [47:0] r_row [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_row[0] <= 48'h0010_0000_0000;
            r_row[1] <= 48'h0000_1000_0000;
            r_row[2] <= 48'h0000_0000_1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ntn_pkg::REG_ENABLE: r_en     <= i_cfg_data[0];
                ntn_pkg::REG_ROW_X:  r_row[0] <= i_cfg_data;
                ntn_pkg::REG_ROW_Y:  r_row[1] <= i_cfg_data;
                ntn_pkg::REG_ROW_Z:  r_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable: advance unless the output holds an untaken result
    logic s_adv;
    assign s_adv   = !o_valid || i_ready;
    assign o_ready = s_adv;

    logic r_vld [Depth];

    // stage 1: products
    logic signed [31:0] r_prod [3][3];
    logic signed [15:0] r_n1 [3];
    logic               r_en1;
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_en1 <= r_en;
            r_n1[0] <= i_normal_in_x;
            r_n1[1] <= i_normal_in_y;
            r_n1[2] <= i_normal_in_z;
            for (int i = 0; i < 3; i++) begin
                r_prod[i][0] <= ntn_pkg::coef_slot(r_row[i][15:0], COEF_WIDTH) * i_normal_in_x;
                r_prod[i][1] <= ntn_pkg::coef_slot(r_row[i][31:16], COEF_WIDTH) * i_normal_in_y;
                r_prod[i][2] <= ntn_pkg::coef_slot(r_row[i][47:32], COEF_WIDTH) * i_normal_in_z;
            end
        end
    end

    // stage 2: sums (or the raw input when the transform is off), magnitudes, signs
    logic [ntn_pkg::MagW-1:0] r_a2 [3];
    logic                     r_neg2 [3];
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [ntn_pkg::VecW-1:0] v;
                v = r_en1 ? (ntn_pkg::VecW'(r_prod[i][0]) + ntn_pkg::VecW'(r_prod[i][1])
                             + ntn_pkg::VecW'(r_prod[i][2]))
                          : ntn_pkg::VecW'(r_n1[i]);
                r_neg2[i] <= v[ntn_pkg::VecW-1];
                r_a2[i]   <= v[ntn_pkg::VecW-1] ? ntn_pkg::MagW'(-v) : ntn_pkg::MagW'(v);
            end
        end
    end

    // stage 3: block scaling by the leading one of the max
    logic [ntn_pkg::MagW-1:0] s_or;
    logic [5:0]               s_lead;
    logic [ntn_pkg::ScW-1:0]  s_sc [3];
    always_comb begin
        s_or   = r_a2[0] | r_a2[1] | r_a2[2];
        s_lead = '0;
        for (int b = 0; b < ntn_pkg::MagW; b++)
            if (s_or[b]) s_lead = 6'(b);
        for (int i = 0; i < 3; i++) begin
            if (s_lead >= 6'd15)
                s_sc[i] = ntn_pkg::ScW'(r_a2[i] >> (s_lead - 6'd15));
            else
                s_sc[i] = ntn_pkg::ScW'(r_a2[i] << (6'd15 - s_lead));
        end
    end

    logic [ntn_pkg::ScW-1:0]  r_sc3 [3];
    logic                     r_neg3 [3];
    logic                     r_zero3;
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_sc3   <= s_sc;
            r_neg3  <= r_neg2;
            r_zero3 <= (s_or == '0);
        end
    end

    // stage 4: sum of squares
    logic [ntn_pkg::ScW-1:0]  r_sc4 [3];
    logic                     r_neg4 [3];
    logic                     r_zero4;
    logic [ntn_pkg::SumW-1:0] r_sum4;
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_sc4   <= r_sc3;
            r_neg4  <= r_neg3;
            r_zero4 <= r_zero3;
            r_sum4  <= ntn_pkg::SumW'(r_sc3[0] * r_sc3[0])
                     + ntn_pkg::SumW'(r_sc3[1] * r_sc3[1])
                     + ntn_pkg::SumW'(r_sc3[2] * r_sc3[2]);
        end
    end

    // square root stages, side data delayed alongside
    logic [ntn_pkg::RootW-1:0] s_len;
    ntn_sqrt u_sqrt (
        .i_clk (i_clk), .i_en (s_adv), .i_sum (r_sum4), .o_root (s_len)
    );

    logic [ntn_pkg::ScW-1:0] r_scd [SqL][3];
    logic                    r_negd [SqL][3];
    logic                    r_zerod [SqL];
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_scd[0] <= r_sc4; r_negd[0] <= r_neg4; r_zerod[0] <= r_zero4;
            for (int k = 1; k < SqL; k++) begin
                r_scd[k] <= r_scd[k-1]; r_negd[k] <= r_negd[k-1];
                r_zerod[k] <= r_zerod[k-1];
            end
        end
    end

    // divide stages, one divider per component; zero case forces divisor 1
    logic [ntn_pkg::RootW-1:0] s_den;
    logic [ntn_pkg::QW-1:0]    s_q [3];
    assign s_den = r_zerod[SqL-1] ? ntn_pkg::RootW'(1) : s_len;
    for (genvar c = 0; c < 3; c++) begin : g_div
        logic [ntn_pkg::NumW-1:0] s_num;
        assign s_num = r_zerod[SqL-1] ? '0
                     : (ntn_pkg::NumW'(r_scd[SqL-1][c]) << 14)
                       + ntn_pkg::NumW'(s_len >> 1);
        ntn_div u_div (
            .i_clk (i_clk), .i_en (s_adv), .i_num (s_num), .i_den (s_den),
            .o_quo (s_q[c])
        );
    end

    logic r_negq [DvL][3];
    logic r_zeroq [DvL];
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_negq[0] <= r_negd[SqL-1]; r_zeroq[0] <= r_zerod[SqL-1];
            for (int k = 1; k < DvL; k++) begin
                r_negq[k] <= r_negq[k-1]; r_zeroq[k] <= r_zeroq[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            o_unit_x <= r_negq[DvL-1][0] ? -$signed({1'b0, s_q[0]}) : $signed({1'b0, s_q[0]});
            o_unit_y <= r_negq[DvL-1][1] ? -$signed({1'b0, s_q[1]}) : $signed({1'b0, s_q[1]});
            o_unit_z <= r_negq[DvL-1][2] ? -$signed({1'b0, s_q[2]}) : $signed({1'b0, s_q[2]});
            o_zero_length <= r_zeroq[DvL-1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) r_vld[k] <= 1'b0;
            o_valid <= 1'b0;
        end else if (s_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < Depth; k++) r_vld[k] <= r_vld[k-1];
            o_valid <= r_vld[Depth-1];
        end
    end

    // a held result stays put while the consumer stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_unit_x) && $stable(o_zero_length))
        else $error("held result changed");
    // a zero-length result carries zero components
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0)
        else $error("zero length with nonzero output");
    // stalls freeze the pipe
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld[Depth-1]))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    localparam int CoefW = 16;
    localparam int Latency = 37;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_normal;

    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic               zero;
    } t_unit;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [ntn_pkg::CfgIdxW-1:0]   i_cfg_idx = '0;
    logic [ntn_pkg::CfgDataW-1:0]  i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [15:0]            i_normal_in_x = '0;
    logic signed [15:0]            i_normal_in_y = '0;
    logic signed [15:0]            i_normal_in_z = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [15:0]            o_unit_x;
    logic signed [15:0]            o_unit_y;
    logic signed [15:0]            o_unit_z;
    logic                          o_zero_length;

    normal_transform_normalize_core #(.COEF_WIDTH(CoefW)) uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic        xf_on;
    logic [47:0] row_m [3];

    t_normal pending_normals[$];
    t_unit   expected_units[$];
    int      errors = 0;
    bit      quiet_mode = 1'b0;   // no idling on either side

    function automatic longint coef_at(input logic [47:0] row, input int slot);
        logic [15:0] raw;
        raw = row[16*slot +: 16];
        if (CoefW < 16) raw = raw & (16'hFFFF << (16 - CoefW));
        return longint'(signed'(raw));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_unit normalize_normal(input t_normal n);
        longint nv[3], v[3];
        longint unsigned a[3], m, s, len, q;
        t_unit r;
        logic [15:0] o[3];
        nv[0] = n.x; nv[1] = n.y; nv[2] = n.z;
        for (int i = 0; i < 3; i++) begin
            if (xf_on) begin
                v[i] = 0;
                for (int k = 0; k < 3; k++) v[i] += coef_at(row_m[i], k) * nv[k];
            end else begin
                v[i] = nv[i];
            end
        end
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) return '{0, 0, 0, 1'b1};
        m = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (a[i] > m) m = a[i];
        end
        while (m < 32768) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        while (m >= 65536) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (a[i] * 16384 + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            o[i] = (v[i] < 0) ? 16'(-q) : 16'(q);
        end
        r.ux = o[0]; r.uy = o[1]; r.uz = o[2]; r.zero = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        errors++;
    endtask

    // driver: one transaction per handshake, random gaps
    logic took;
    always @(posedge i_clk) took <= i_rst_n && i_valid && o_ready;

    always @(negedge i_clk) begin
        t_normal nx;
        if (i_rst_n) begin
            if (!i_valid || took) begin
                if (pending_normals.size() > 0 && (quiet_mode || $urandom_range(99) >= 24)) begin
                    nx = pending_normals.pop_front();
                    i_normal_in_x <= nx.x;
                    i_normal_in_y <= nx.y;
                    i_normal_in_z <= nx.z;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= quiet_mode || ($urandom_range(99) >= 24);
        end
    end

    // predictor runs on each accepted input transaction
    always @(posedge i_clk) begin
        t_normal acc;
        t_unit got, exp;
        if (i_rst_n && i_valid && o_ready) begin
            acc = '{i_normal_in_x, i_normal_in_y, i_normal_in_z};
            expected_units.push_back(normalize_normal(acc));
        end
        // monitor
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_unit_x, o_unit_y, o_unit_z, o_zero_length};
            if (expected_units.size() == 0) begin
                $display("unexpected output transaction");
                errors++;
            end else begin
                exp = expected_units.pop_front();
                if (got.ux !== exp.ux) report_mismatch("unit_x", got.ux, exp.ux);
                if (got.uy !== exp.uy) report_mismatch("unit_y", got.uy, exp.uy);
                if (got.uz !== exp.uz) report_mismatch("unit_z", got.uz, exp.uz);
                if (got.zero !== exp.zero) report_mismatch("zero_length", got.zero, exp.zero);
            end
        end
    end

    task automatic cfg_write(input logic [ntn_pkg::CfgIdxW-1:0] idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ntn_pkg::REG_ENABLE: xf_on = val[0];
            ntn_pkg::REG_ROW_X:  row_m[0] = val;
            ntn_pkg::REG_ROW_Y:  row_m[1] = val;
            ntn_pkg::REG_ROW_Z:  row_m[2] = val;
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (pending_normals.size() > 0 || i_valid || expected_units.size() > 0)
            @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_comp();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(8)) - 16'd4;
            3: return 16'(signed'(16'($urandom_range(8191))) - 16'sd4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rnd_row();
        logic [47:0] r;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(3))
                0: r[16*k +: 16] = 16'h0000;
                1: r[16*k +: 16] = 16'(signed'(16'($urandom_range(8192))) - 16'sd4096);
                default: r[16*k +: 16] = 16'($urandom);
            endcase
        end
        return r;
    endfunction

    function automatic t_normal rnd_normal();
        return '{rnd_comp(), rnd_comp(), rnd_comp()};
    endfunction

    initial begin
        xf_on = 1'b0;
        row_m[0] = 48'h001000000000;
        row_m[1] = 48'h000010000000;
        row_m[2] = 48'h000000001000;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and the zero vector, pass-through first
        pending_normals.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
        pending_normals.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_normals.push_back('{-16'sh8000, -16'sh8000, -16'sh8000});
        pending_normals.push_back('{16'sh7FFF, -16'sh8000, 16'sh0000});
        pending_normals.push_back('{16'sh0001, 16'sh0000, 16'sh0000});
        pending_normals.push_back('{16'sh0000, -16'sh0001, 16'sh0000});
        pending_normals.push_back('{16'sh0000, 16'sh0000, 16'sh1000});
        pending_normals.push_back('{16'sh0001, 16'sh0001, 16'sh0001});
        pending_normals.push_back('{-16'sh1000, 16'sh1000, -16'sh0001});
        drain_all();

        // reset matrix on, then extremes of coefficients
        cfg_write(ntn_pkg::REG_ENABLE, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++) pending_normals.push_back(rnd_normal());
        pending_normals.push_back('{16'sh7FFF, -16'sh8000, 16'sh7FFF});
        drain_all();
        cfg_write(ntn_pkg::REG_ROW_X, 48'h7FFF_7FFF_7FFF);
        cfg_write(ntn_pkg::REG_ROW_Y, 48'h8000_8000_8000);
        cfg_write(ntn_pkg::REG_ROW_Z, 48'hFFFF_FFFF_FFFF);
        pending_normals.push_back('{-16'sh8000, -16'sh8000, -16'sh8000});
        pending_normals.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_normals.push_back('{16'sh0001, -16'sh0001, 16'sh0000});
        pending_normals.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
        drain_all();
        // singular matrix: zero vectors from nonzero input
        cfg_write(ntn_pkg::REG_ROW_X, 48'h0);
        cfg_write(ntn_pkg::REG_ROW_Y, 48'h0);
        cfg_write(ntn_pkg::REG_ROW_Z, 48'h0);
        pending_normals.push_back('{16'sh1234, -16'sh0567, 16'sh7FFF});
        drain_all();

        // random phases, each with new settings
        for (int ph = 0; ph < 7; ph++) begin
            cfg_write(ntn_pkg::REG_ENABLE, 48'($urandom_range(3)));
            cfg_write(ntn_pkg::REG_ROW_X, rnd_row());
            cfg_write(ntn_pkg::REG_ROW_Y, rnd_row());
            cfg_write(ntn_pkg::REG_ROW_Z, rnd_row());
            quiet_mode = (ph == 3);
            for (int i = 0; i < 100; i++) pending_normals.push_back(rnd_normal());
            drain_all();
        end
        quiet_mode = 1'b0;

        if (errors == 0 && expected_units.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/ntn_pkg.sv
rtl/core/ntn_sqrt.sv
rtl/core/ntn_div.sv
rtl/core/normal_transform_normalize_core.sv
tb/tb.sv
